// ----- src/e2q_pkg.sv -----
// Package for the Euler-angle to quaternion converter: Q30 widths, angle
// constants, the CORDIC arctangent table and the stage payload types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package e2q_pkg;

  localparam int QW           = 34;
  localparam int ONE_SHIFT    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int MAG_W        = 32;
  localparam int LEN_W        = 32;
  localparam int SUM_W        = 64;
  localparam int LAT_BASE     = 72;

  typedef logic signed [QW-1:0] q30_t;

  localparam q30_t PI_Q30      = 34'sd3373259426;
  localparam q30_t HALF_PI_Q30 = 34'sd1686629713;
  localparam q30_t GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
  } cordic_lane_t;

  typedef struct packed {
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } comp_side_t;

  function automatic q30_t atan_q30(input int unsigned idx);
    q30_t v;
    case (idx)
      0:  v = QW'(32'h3243F6A8);
      1:  v = QW'(32'h1DAC6705);
      2:  v = QW'(32'h0FADBAFC);
      3:  v = QW'(32'h07F56EA6);
      4:  v = QW'(32'h03FEAB76);
      5:  v = QW'(32'h01FFD55B);
      6:  v = QW'(32'h00FFFAAA);
      7:  v = QW'(32'h007FFF55);
      8:  v = QW'(32'h003FFFEA);
      9:  v = QW'(32'h001FFFFD);
      10: v = QW'(32'h000FFFFF);
      11: v = QW'(32'h0007FFFF);
      12: v = QW'(32'h0003FFFF);
      13: v = QW'(32'h0001FFFF);
      14: v = QW'(32'h0000FFFF);
      15: v = QW'(32'h00007FFF);
      16: v = QW'(32'h00003FFF);
      17: v = QW'(32'h00001FFF);
      18: v = QW'(32'h00000FFF);
      19: v = QW'(32'h000007FF);
      20: v = QW'(32'h000003FF);
      21: v = QW'(32'h000001FF);
      22: v = QW'(32'h000000FF);
      23: v = QW'(32'h0000007F);
      24: v = QW'(32'h0000003F);
      25: v = QW'(32'h0000001F);
      26: v = QW'(32'h0000000F);
      27: v = QW'(32'h00000008);
      28: v = QW'(32'h00000004);
      29: v = QW'(32'h00000002);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- src/e2q_cordic_stage.sv -----
// One registered rotation step of the sine/cosine CORDIC, applied to the
// roll, pitch and yaw lanes side by side. Depends on e2q_pkg.
`default_nettype none

module e2q_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire e2q_pkg::cordic_lane_t [2:0]  in_lane,
  input  wire logic [2:0]                   in_neg,
  output logic                              out_valid,
  output e2q_pkg::cordic_lane_t [2:0]       out_lane,
  output logic [2:0]                        out_neg
);

  localparam e2q_pkg::q30_t ATAN = e2q_pkg::atan_q30(STEP);

  logic                         valid_r;
  e2q_pkg::cordic_lane_t [2:0]  lane_r, lane_nxt;
  logic [2:0]                   neg_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!in_lane[l].z[e2q_pkg::QW-1]) begin
        lane_nxt[l].x = in_lane[l].x - (in_lane[l].y >>> STEP);
        lane_nxt[l].y = in_lane[l].y + (in_lane[l].x >>> STEP);
        lane_nxt[l].z = in_lane[l].z - ATAN;
      end else begin
        lane_nxt[l].x = in_lane[l].x + (in_lane[l].y >>> STEP);
        lane_nxt[l].y = in_lane[l].y - (in_lane[l].x >>> STEP);
        lane_nxt[l].z = in_lane[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    neg_r  <= in_neg;
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign out_neg   = neg_r;

endmodule

`default_nettype wire

// ----- src/e2q_isqrt_stage.sv -----
// One registered step of the bit-pair integer square root of the sum of
// squares, carrying the component signs and magnitudes. Depends on e2q_pkg.
`default_nettype none

module e2q_isqrt_stage #(
  parameter int STEP = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [e2q_pkg::SUM_W-1:0]   in_rem,
  input  wire logic [e2q_pkg::SUM_W-1:0]   in_root,
  input  wire e2q_pkg::comp_side_t         in_side,
  output logic                             out_valid,
  output logic [e2q_pkg::SUM_W-1:0]        out_rem,
  output logic [e2q_pkg::SUM_W-1:0]        out_root,
  output e2q_pkg::comp_side_t              out_side
);

  localparam logic [e2q_pkg::SUM_W-1:0] BIT_VAL =
    e2q_pkg::SUM_W'(1) << (e2q_pkg::SUM_W - 2 - 2 * STEP);

  logic                        valid_r;
  logic [e2q_pkg::SUM_W-1:0]   rem_r, rem_nxt;
  logic [e2q_pkg::SUM_W-1:0]   root_r, root_nxt;
  logic [e2q_pkg::SUM_W-1:0]   trial;
  e2q_pkg::comp_side_t         side_r;

  always_comb begin
    trial = in_root + BIT_VAL;
    if (in_rem >= trial) begin
      rem_nxt  = in_rem - trial;
      root_nxt = (in_root >> 1) + BIT_VAL;
    end else begin
      rem_nxt  = in_rem;
      root_nxt = in_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ----- src/e2q_div_stage.sv -----
// One registered restoring-division step that produces one quotient bit of
// each of the four scaled components. Depends on e2q_pkg.
`default_nettype none

module e2q_div_stage #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int STEP            = 0
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  input  wire logic [3:0][COMPONENT_WIDTH+30:0]         in_rem,
  input  wire logic [3:0][COMPONENT_WIDTH-1:0]          in_quot,
  input  wire logic [3:0]                               in_neg,
  input  wire logic [e2q_pkg::LEN_W-1:0]                in_len,
  output logic                                          out_valid,
  output logic [3:0][COMPONENT_WIDTH+30:0]              out_rem,
  output logic [3:0][COMPONENT_WIDTH-1:0]               out_quot,
  output logic [3:0]                                    out_neg,
  output logic [e2q_pkg::LEN_W-1:0]                     out_len
);

  localparam int NW = COMPONENT_WIDTH + 31;

  logic                                   valid_r;
  logic [3:0][NW-1:0]                     rem_r, rem_nxt;
  logic [3:0][COMPONENT_WIDTH-1:0]        quot_r, quot_nxt;
  logic [3:0]                             neg_r;
  logic [e2q_pkg::LEN_W-1:0]              len_r;
  logic [NW-1:0]                          divisor;

  always_comb begin
    divisor = NW'(in_len) << STEP;
    for (int k = 0; k < 4; k++) begin
      quot_nxt[k] = in_quot[k];
      if (in_rem[k] >= divisor) begin
        rem_nxt[k]        = in_rem[k] - divisor;
        quot_nxt[k][STEP] = 1'b1;
      end else begin
        rem_nxt[k] = in_rem[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    neg_r  <= in_neg;
    len_r  <= in_len;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quot  = quot_r;
  assign out_neg   = neg_r;
  assign out_len   = len_r;

endmodule

`default_nettype wire

// ----- src/euler_to_quaternion.sv -----
// Top level of the Euler-angle to unit quaternion converter.
// Depends on e2q_pkg, e2q_cordic_stage, e2q_isqrt_stage and e2q_div_stage.
//
// The converter is a fully pipelined datapath that takes one item on every
// clock cycle and never holds the sender off, so busy stays low. Each result
// is shown on out_valid for one cycle, in order. The path runs through the
// 30 CORDIC steps, the 32 square-root steps, one division step per output
// bit and ten fixed stages for the input fold, the products, the sum of
// squares, the rounding and the output register. The receiver must take
// every result in the cycle it is shown.
`default_nettype none

module euler_to_quaternion #(
  parameter int ANGLE_WIDTH     = 16,
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [ANGLE_WIDTH-1:0]      in_roll_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0]      in_pitch_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0]      in_yaw_angle,
  output logic                                    out_valid,
  output logic signed [COMPONENT_WIDTH-1:0]       out_quat_w,
  output logic signed [COMPONENT_WIDTH-1:0]       out_quat_x,
  output logic signed [COMPONENT_WIDTH-1:0]       out_quat_y,
  output logic signed [COMPONENT_WIDTH-1:0]       out_quat_z
);

  localparam int QW    = e2q_pkg::QW;
  localparam int CW    = COMPONENT_WIDTH;
  localparam int NW    = CW + 31;
  localparam int HSH   = 32 - ANGLE_WIDTH;
  localparam int NCS   = e2q_pkg::CORDIC_STEPS;
  localparam int NSQ   = e2q_pkg::SQRT_STEPS;
  localparam logic [CW-1:0] ONE = CW'(1) << (CW - 2);

  function automatic e2q_pkg::q30_t mul_q30(input e2q_pkg::q30_t a,
                                            input e2q_pkg::q30_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return QW'(p >>> e2q_pkg::ONE_SHIFT);
  endfunction

  function automatic e2q_pkg::q30_t half_q30(input logic signed [ANGLE_WIDTH-1:0] a);
    e2q_pkg::q30_t h;
    h = QW'(a);
    return h <<< HSH;
  endfunction

  assign busy = 1'b0;

  // Input stage: half angle and fold into the CORDIC range.
  logic                         v0_r;
  e2q_pkg::cordic_lane_t [2:0]  lane0_r, lane0_nxt;
  logic [2:0]                   neg0_r, neg0_nxt;
  e2q_pkg::q30_t                half [3];

  always_comb begin
    half[0] = half_q30(in_roll_angle);
    half[1] = half_q30(in_pitch_angle);
    half[2] = half_q30(in_yaw_angle);
    for (int l = 0; l < 3; l++) begin
      lane0_nxt[l].x = e2q_pkg::GAIN_Q30;
      lane0_nxt[l].y = '0;
      if (half[l] > e2q_pkg::HALF_PI_Q30) begin
        lane0_nxt[l].z = half[l] - e2q_pkg::PI_Q30;
        neg0_nxt[l]    = 1'b1;
      end else if (half[l] < -e2q_pkg::HALF_PI_Q30) begin
        lane0_nxt[l].z = half[l] + e2q_pkg::PI_Q30;
        neg0_nxt[l]    = 1'b1;
      end else begin
        lane0_nxt[l].z = half[l];
        neg0_nxt[l]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    lane0_r <= lane0_nxt;
    neg0_r  <= neg0_nxt;
  end

  // CORDIC chain.
  logic                         cv [0:NCS];
  e2q_pkg::cordic_lane_t [2:0]  cl [0:NCS];
  logic [2:0]                   cn [0:NCS];

  assign cv[0] = v0_r;
  assign cl[0] = lane0_r;
  assign cn[0] = neg0_r;

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    e2q_cordic_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_lane   (cl[i]),
      .in_neg    (cn[i]),
      .out_valid (cv[i+1]),
      .out_lane  (cl[i+1]),
      .out_neg   (cn[i+1])
    );
  end

  // Sign restore: index 0 roll, 1 pitch, 2 yaw.
  logic                vsc_r;
  e2q_pkg::q30_t       sin_r [3];
  e2q_pkg::q30_t       cos_r [3];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      sin_r[l] <= cn[NCS][l] ? -cl[NCS][l].y : cl[NCS][l].y;
      cos_r[l] <= cn[NCS][l] ? -cl[NCS][l].x : cl[NCS][l].x;
    end
  end

  // Pair products.
  logic           vpa_r;
  e2q_pkg::q30_t  crcp_r, srsp_r, srcp_r, crsp_r;
  e2q_pkg::q30_t  cy_r, sy_r;

  always_ff @(posedge clk) begin
    crcp_r <= mul_q30(cos_r[0], cos_r[1]);
    srsp_r <= mul_q30(sin_r[0], sin_r[1]);
    srcp_r <= mul_q30(sin_r[0], cos_r[1]);
    crsp_r <= mul_q30(cos_r[0], sin_r[1]);
    cy_r   <= cos_r[2];
    sy_r   <= sin_r[2];
  end

  // Triple products.
  logic           vpb_r;
  e2q_pkg::q30_t  tp_r [8];

  always_ff @(posedge clk) begin
    tp_r[0] <= mul_q30(crcp_r, cy_r);
    tp_r[1] <= mul_q30(srsp_r, sy_r);
    tp_r[2] <= mul_q30(srcp_r, cy_r);
    tp_r[3] <= mul_q30(crsp_r, sy_r);
    tp_r[4] <= mul_q30(crsp_r, cy_r);
    tp_r[5] <= mul_q30(srcp_r, sy_r);
    tp_r[6] <= mul_q30(crcp_r, sy_r);
    tp_r[7] <= mul_q30(srsp_r, cy_r);
  end

  // Components as sign and magnitude.
  logic                      vq_r;
  e2q_pkg::comp_side_t       side_q_r, side_q_nxt;
  logic signed [QW:0]        qc [4];

  always_comb begin
    qc[0] = (QW+1)'(tp_r[0]) + (QW+1)'(tp_r[1]);
    qc[1] = (QW+1)'(tp_r[2]) - (QW+1)'(tp_r[3]);
    qc[2] = (QW+1)'(tp_r[4]) + (QW+1)'(tp_r[5]);
    qc[3] = (QW+1)'(tp_r[6]) - (QW+1)'(tp_r[7]);
    for (int k = 0; k < 4; k++) begin
      side_q_nxt.neg[k] = qc[k][QW];
      side_q_nxt.mag[k] = e2q_pkg::MAG_W'(qc[k][QW] ? -qc[k] : qc[k]);
    end
  end

  always_ff @(posedge clk) begin
    side_q_r <= side_q_nxt;
  end

  // Squares, then a two-level sum.
  logic                          vsq_r, vps_r, vsum_r;
  logic [e2q_pkg::SUM_W-1:0]     sq_r [4];
  logic [e2q_pkg::SUM_W-1:0]     ps_r [2];
  logic [e2q_pkg::SUM_W-1:0]     sum_r;
  e2q_pkg::comp_side_t           side_sq_r, side_ps_r, side_sum_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= side_q_r.mag[k] * side_q_r.mag[k];
    end
    ps_r[0]    <= sq_r[0] + sq_r[1];
    ps_r[1]    <= sq_r[2] + sq_r[3];
    sum_r      <= ps_r[0] + ps_r[1];
    side_sq_r  <= side_q_r;
    side_ps_r  <= side_sq_r;
    side_sum_r <= side_ps_r;
  end

  // Square-root chain.
  logic                        sv [0:NSQ];
  logic [e2q_pkg::SUM_W-1:0]   srem [0:NSQ];
  logic [e2q_pkg::SUM_W-1:0]   sroot [0:NSQ];
  e2q_pkg::comp_side_t         sside [0:NSQ];

  assign sv[0]    = vsum_r;
  assign srem[0]  = sum_r;
  assign sroot[0] = '0;
  assign sside[0] = side_sum_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_isqrt
    e2q_isqrt_stage #(.STEP(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sv[i]),
      .in_rem    (srem[i]),
      .in_root   (sroot[i]),
      .in_side   (sside[i]),
      .out_valid (sv[i+1]),
      .out_rem   (srem[i+1]),
      .out_root  (sroot[i+1]),
      .out_side  (sside[i+1])
    );
  end

  // Rounded dividends.
  logic                           vpr_r;
  logic [3:0][NW-1:0]             num_r;
  logic [3:0]                     neg_pr_r;
  logic [e2q_pkg::LEN_W-1:0]      len_pr_r, len_w;

  assign len_w = e2q_pkg::LEN_W'(sroot[NSQ]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      num_r[k] <= (NW'(sside[NSQ].mag[k]) << (CW - 2)) + NW'(len_w >> 1);
    end
    neg_pr_r <= sside[NSQ].neg;
    len_pr_r <= len_w;
  end

  // Division chain, most significant quotient bit first.
  logic                          dv [0:CW];
  logic [3:0][NW-1:0]            drem [0:CW];
  logic [3:0][CW-1:0]            dquot [0:CW];
  logic [3:0]                    dneg [0:CW];
  logic [e2q_pkg::LEN_W-1:0]     dlen [0:CW];

  assign dv[0]    = vpr_r;
  assign drem[0]  = num_r;
  assign dquot[0] = '0;
  assign dneg[0]  = neg_pr_r;
  assign dlen[0]  = len_pr_r;

  for (genvar i = 0; i < CW; i++) begin : g_div
    e2q_div_stage #(.COMPONENT_WIDTH(CW), .STEP(CW - 1 - i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv[i]),
      .in_rem    (drem[i]),
      .in_quot   (dquot[i]),
      .in_neg    (dneg[i]),
      .in_len    (dlen[i]),
      .out_valid (dv[i+1]),
      .out_rem   (drem[i+1]),
      .out_quot  (dquot[i+1]),
      .out_neg   (dneg[i+1]),
      .out_len   (dlen[i+1])
    );
  end

  // Clamp, sign and output register.
  logic                   out_valid_r;
  logic [3:0][CW-1:0]     comp_r, comp_nxt;
  logic [CW-1:0]          clamp;

  always_comb begin
    clamp = '0;
    for (int k = 0; k < 4; k++) begin
      clamp       = (dquot[CW][k] > ONE) ? ONE : dquot[CW][k];
      comp_nxt[k] = dneg[CW][k] ? CW'(-clamp) : clamp;
    end
    if (dlen[CW] == '0) begin
      comp_nxt[0] = ONE;
      comp_nxt[1] = '0;
      comp_nxt[2] = '0;
      comp_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsc_r       <= 1'b0;
      vpa_r       <= 1'b0;
      vpb_r       <= 1'b0;
      vq_r        <= 1'b0;
      vsq_r       <= 1'b0;
      vps_r       <= 1'b0;
      vsum_r      <= 1'b0;
      vpr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vsc_r       <= cv[NCS];
      vpa_r       <= vsc_r;
      vpb_r       <= vpa_r;
      vq_r        <= vpb_r;
      vsq_r       <= vq_r;
      vps_r       <= vsq_r;
      vsum_r      <= vps_r;
      vpr_r       <= sv[NSQ];
      out_valid_r <= dv[CW];
    end
  end

  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = comp_r[0];
  assign out_quat_x = comp_r[1];
  assign out_quat_y = comp_r[2];
  assign out_quat_z = comp_r[3];

endmodule

`default_nettype wire

// ----- src/e2q_checker.sv -----
// Port-level checks for the Euler-angle to quaternion converter, bound to
// the top level. Depends on e2q_pkg and euler_to_quaternion.
`default_nettype none

module e2q_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic signed [COMPONENT_WIDTH-1:0]  out_quat_w,
  input wire logic signed [COMPONENT_WIDTH-1:0]  out_quat_x,
  input wire logic signed [COMPONENT_WIDTH-1:0]  out_quat_y,
  input wire logic signed [COMPONENT_WIDTH-1:0]  out_quat_z
);

  localparam int LAT = e2q_pkg::LAT_BASE + COMPONENT_WIDTH;
  localparam logic signed [COMPONENT_WIDTH-1:0] ONE =
    COMPONENT_WIDTH'(1) << (COMPONENT_WIDTH - 2);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without an item accepted at the fixed latency");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= ONE && out_quat_w >= -ONE &&
                   out_quat_x <= ONE && out_quat_x >= -ONE &&
                   out_quat_y <= ONE && out_quat_y >= -ONE &&
                   out_quat_z <= ONE && out_quat_z >= -ONE))
    else $error("component outside plus or minus one");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_quat_w == '0 && out_quat_x == '0 &&
                    out_quat_y == '0 && out_quat_z == '0))
    else $error("all-zero quaternion");

endmodule

bind euler_to_quaternion e2q_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_e2q_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_quat_w (out_quat_w),
  .out_quat_x (out_quat_x),
  .out_quat_y (out_quat_y),
  .out_quat_z (out_quat_z)
);

`default_nettype wire
